// ===== rtl/cesd_pkg.sv =====
// Package for the C string escape decoder.
// Holds the widths, the result entry type and the character class helpers.
// No dependencies.
package cesd_pkg;

   localparam int BYTE_BITS    = 8;
   localparam int LENGTH_BITS  = 16;
   localparam int VALUE_BITS   = 9;
   localparam int DIGIT_BITS   = 2;
   localparam int RESULT_SLOTS = 3;
   localparam int SLOT_BITS    = 2;

   localparam logic [BYTE_BITS-1:0] CHAR_BACKSLASH = 8'h5C;
   localparam logic [BYTE_BITS-1:0] CHAR_QUOTE     = 8'h27;
   localparam logic [BYTE_BITS-1:0] CHAR_DQUOTE    = 8'h22;
   localparam logic [BYTE_BITS-1:0] CHAR_QUESTION  = 8'h3F;
   localparam logic [BYTE_BITS-1:0] CHAR_X         = 8'h78;

   localparam logic [DIGIT_BITS-1:0] OCT_MAX_DIGITS = 2'd3;
   localparam logic [DIGIT_BITS-1:0] HEX_DIGITS     = 2'd2;

   typedef struct packed {
      logic [BYTE_BITS-1:0]   data;
      logic                   last;
      logic                   error;
      logic [LENGTH_BITS-1:0] length;
   } entry_type;

   typedef struct packed {
      logic       valid;
      logic [3:0] value;
   } digit_type;

   typedef struct packed {
      logic                 valid;
      logic [BYTE_BITS-1:0] value;
   } escape_type;

   function automatic digit_type oct_digit(input logic [BYTE_BITS-1:0] b);
      digit_type d;
      d.valid = (b >= 8'h30) && (b <= 8'h37);
      d.value = {1'b0, b[2:0]};
      return d;
   endfunction

   function automatic digit_type hex_digit(input logic [BYTE_BITS-1:0] b);
      digit_type d;
      d.valid = 1'b1;
      d.value = 4'd0;
      if ((b >= 8'h30) && (b <= 8'h39)) begin
         d.value = b[3:0];
      end else if (((b >= 8'h61) && (b <= 8'h66)) || ((b >= 8'h41) && (b <= 8'h46))) begin
         d.value = b[3:0] + 4'd9;
      end else begin
         d.valid = 1'b0;
      end
      return d;
   endfunction

   // Single-character escapes; anything else is malformed.
   function automatic escape_type simple_escape(input logic [BYTE_BITS-1:0] b);
      escape_type e;
      e.valid = 1'b1;
      case (b)
         8'h6E:          e.value = 8'd10;
         8'h74:          e.value = 8'd9;
         8'h62:          e.value = 8'd8;
         8'h76:          e.value = 8'd11;
         8'h72:          e.value = 8'd13;
         8'h66:          e.value = 8'd12;
         CHAR_BACKSLASH: e.value = CHAR_BACKSLASH;
         CHAR_QUOTE:     e.value = CHAR_QUOTE;
         CHAR_DQUOTE:    e.value = CHAR_DQUOTE;
         CHAR_QUESTION:  e.value = CHAR_QUESTION;
         default: begin
            e.valid = 1'b0;
            e.value = '0;
         end
      endcase
      return e;
   endfunction

endpackage

// ===== rtl/c_escape_string_decoder.sv =====
// C string escape decoder: one body byte in per transfer, decoded bytes out.
// Results are registered: a result appears in the cycle after its input transfer.
// Throughput: one input byte per cycle while each byte yields at most one result
// and the response side is ready; a byte yielding two or three results holds the
// input while the three-entry result buffer drains.
// Reset: synchronous, active high; clears the decoder state and the result buffer.
// Depends on cesd_pkg.
module c_escape_string_decoder
   import cesd_pkg::*;
(
   input  logic        clock,
   input  logic        reset,
   input  logic        req_tvalid,
   output logic        req_tready,
   input  logic [7:0]  req_tdata,   // [7:0] in_byte
   input  logic        req_tlast,   // in_last
   output logic        rsp_tvalid,
   input  logic        rsp_tready,
   output logic [23:0] rsp_tdata,   // [7:0] out_byte, [23:8] out_length
   output logic        rsp_tlast,   // out_last
   output logic        rsp_tuser    // out_error
);

   typedef enum logic [2:0] {
      MODE_NORMAL  = 3'd0,
      MODE_ESC     = 3'd1,
      MODE_OCT     = 3'd2,
      MODE_HEX     = 3'd3,
      MODE_DISCARD = 3'd4
   } mode_type;

   mode_type               mode_ff, mode_in;
   logic [DIGIT_BITS-1:0]  digits_ff, digits_in;
   logic [VALUE_BITS-1:0]  value_ff, value_in;
   logic [LENGTH_BITS-1:0] count_ff, count_in;
   entry_type              slot_ff [RESULT_SLOTS];
   entry_type              slot_in [RESULT_SLOTS];
   logic [SLOT_BITS-1:0]   fill_ff, fill_in;

   entry_type              res [RESULT_SLOTS];
   logic [SLOT_BITS-1:0]   res_n;
   logic                   err;
   logic                   plain;
   digit_type              od, hd;
   escape_type             se;
   logic                   accept, pop;

   assign accept = req_tvalid && req_tready;
   assign pop    = rsp_tvalid && rsp_tready;

   // Accept when the buffer is empty or its last entry leaves this cycle.
   assign req_tready = (fill_ff == '0) || ((fill_ff == SLOT_BITS'(1)) && rsp_tready);

   assign od = oct_digit(req_tdata);
   assign hd = hex_digit(req_tdata);
   assign se = simple_escape(req_tdata);

   // Decode one byte: up to three results appended in order.
   always_comb begin
      mode_in   = mode_ff;
      digits_in = digits_ff;
      value_in  = value_ff;
      count_in  = count_ff;
      res_n     = '0;
      err       = 1'b0;
      plain     = 1'b0;
      for (int i = 0; i < RESULT_SLOTS; i++) begin
         res[i] = '0;
      end

      if (mode_ff == MODE_DISCARD) begin
         if (req_tlast) begin
            mode_in   = MODE_NORMAL;
            digits_in = '0;
            value_in  = '0;
            count_in  = '0;
         end
      end else begin
         case (mode_ff)
            MODE_OCT: begin
               if (od.valid) begin
                  if (digits_ff >= OCT_MAX_DIGITS) begin
                     err = 1'b1;
                  end else begin
                     value_in  = {value_ff[VALUE_BITS-4:0], od.value[2:0]};
                     digits_in = digits_ff + DIGIT_BITS'(1);
                  end
               end else begin
                  if (count_in != '1) count_in = count_in + LENGTH_BITS'(1);
                  res[res_n] = '{data: value_ff[7:0], last: 1'b0, error: 1'b0,
                                 length: count_in};
                  res_n   = res_n + SLOT_BITS'(1);
                  mode_in = MODE_NORMAL;
                  plain   = 1'b1;
               end
            end
            MODE_HEX: begin
               if (hd.valid) begin
                  if (digits_ff >= HEX_DIGITS) begin
                     err = 1'b1;
                  end else begin
                     value_in  = {value_ff[VALUE_BITS-5:0], hd.value};
                     digits_in = digits_ff + DIGIT_BITS'(1);
                  end
               end else if (digits_ff != HEX_DIGITS) begin
                  err = 1'b1;
               end else begin
                  if (count_in != '1) count_in = count_in + LENGTH_BITS'(1);
                  res[res_n] = '{data: value_ff[7:0], last: 1'b0, error: 1'b0,
                                 length: count_in};
                  res_n   = res_n + SLOT_BITS'(1);
                  mode_in = MODE_NORMAL;
                  plain   = 1'b1;
               end
            end
            MODE_ESC: begin
               if (od.valid) begin
                  mode_in   = MODE_OCT;
                  digits_in = DIGIT_BITS'(1);
                  value_in  = VALUE_BITS'(od.value[2:0]);
               end else if (req_tdata == CHAR_X) begin
                  mode_in   = MODE_HEX;
                  digits_in = '0;
                  value_in  = '0;
               end else if (se.valid) begin
                  if (count_in != '1) count_in = count_in + LENGTH_BITS'(1);
                  res[res_n] = '{data: se.value, last: 1'b0, error: 1'b0,
                                 length: count_in};
                  res_n   = res_n + SLOT_BITS'(1);
                  mode_in = MODE_NORMAL;
               end else begin
                  err = 1'b1;
               end
            end
            default: plain = 1'b1;
         endcase

         if (plain) begin
            if (req_tdata == CHAR_BACKSLASH) begin
               mode_in = MODE_ESC;
            end else begin
               if (count_in != '1) count_in = count_in + LENGTH_BITS'(1);
               res[res_n] = '{data: req_tdata, last: 1'b0, error: 1'b0,
                              length: count_in};
               res_n   = res_n + SLOT_BITS'(1);
               mode_in = MODE_NORMAL;
            end
         end

         // End of string: flush an open octal or complete hex escape; an open backslash or short hex run is an error.
         if (!err && req_tlast) begin
            if (mode_in == MODE_ESC) begin
               err = 1'b1;
            end else if ((mode_in == MODE_OCT) ||
                         ((mode_in == MODE_HEX) && (digits_in == HEX_DIGITS))) begin
               if (count_in != '1) count_in = count_in + LENGTH_BITS'(1);
               res[res_n] = '{data: value_in[7:0], last: 1'b0, error: 1'b0,
                              length: count_in};
               res_n = res_n + SLOT_BITS'(1);
            end else if (mode_in == MODE_HEX) begin
               err = 1'b1;
            end
         end

         if (err) begin
            res[res_n] = '{data: '0, last: 1'b1, error: 1'b1, length: count_in};
            res_n = res_n + SLOT_BITS'(1);
            if (req_tlast) begin
               mode_in   = MODE_NORMAL;
               digits_in = '0;
               value_in  = '0;
               count_in  = '0;
            end else begin
               mode_in = MODE_DISCARD;
            end
         end else if (req_tlast) begin
            if (count_in != '1) count_in = count_in + LENGTH_BITS'(1);
            res[res_n] = '{data: '0, last: 1'b1, error: 1'b0, length: count_in};
            res_n     = res_n + SLOT_BITS'(1);
            mode_in   = MODE_NORMAL;
            digits_in = '0;
            value_in  = '0;
            count_in  = '0;
         end
      end
   end

   // Result buffer: a new item loads only into an empty (or emptying) buffer.
   always_comb begin
      fill_in = fill_ff;
      for (int i = 0; i < RESULT_SLOTS; i++) begin
         slot_in[i] = slot_ff[i];
      end
      if (accept) begin
         for (int i = 0; i < RESULT_SLOTS; i++) begin
            slot_in[i] = res[i];
         end
         fill_in = res_n;
      end else if (pop) begin
         for (int i = 0; i < RESULT_SLOTS - 1; i++) begin
            slot_in[i] = slot_ff[i+1];
         end
         fill_in = fill_ff - SLOT_BITS'(1);
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         mode_ff   <= MODE_NORMAL;
         digits_ff <= '0;
         value_ff  <= '0;
         count_ff  <= '0;
         fill_ff   <= '0;
      end else begin
         if (accept) begin
            mode_ff   <= mode_in;
            digits_ff <= digits_in;
            value_ff  <= value_in;
            count_ff  <= count_in;
         end
         fill_ff <= fill_in;
      end
   end

   always_ff @(posedge clock) begin
      for (int i = 0; i < RESULT_SLOTS; i++) begin
         slot_ff[i] <= slot_in[i];
      end
   end

   assign rsp_tvalid = (fill_ff != '0);
   assign rsp_tdata  = {slot_ff[0].length, slot_ff[0].data};
   assign rsp_tlast  = slot_ff[0].last;
   assign rsp_tuser  = slot_ff[0].error;

endmodule

// ===== rtl/cesd_checker.sv =====
// Port-level checks for the C string escape decoder.
// Bound to c_escape_string_decoder; uses no package items.
module cesd_checker (
   input logic        clock,
   input logic        reset,
   input logic        rsp_tvalid,
   input logic        rsp_tready,
   input logic [23:0] rsp_tdata,
   input logic        rsp_tlast,
   input logic        rsp_tuser
);

   // A waiting result must hold until it is taken.
   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && !rsp_tready |=> rsp_tvalid && $stable(rsp_tdata) &&
                                    $stable(rsp_tlast) && $stable(rsp_tuser))
      else $error("result changed while stalled");

   // An error result always ends the string.
   a_err_last: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && rsp_tuser |-> rsp_tlast)
      else $error("error result without tlast");

   // Terminator and error results carry a zero byte.
   a_last_zero: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && rsp_tlast |-> rsp_tdata[7:0] == 8'h00)
      else $error("nonzero byte on closing result");

   // A terminator counts itself, so its length is never zero.
   a_term_len: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && rsp_tlast && !rsp_tuser |-> rsp_tdata[23:8] != 16'h0000)
      else $error("terminator with zero length");

   // The result buffer comes out of reset empty.
   a_reset_empty: assert property (@(posedge clock)
      $past(reset) |-> !rsp_tvalid)
      else $error("result valid right after reset");

endmodule

bind c_escape_string_decoder cesd_checker u_cesd_checker (
   .clock      (clock),
   .reset      (reset),
   .rsp_tvalid (rsp_tvalid),
   .rsp_tready (rsp_tready),
   .rsp_tdata  (rsp_tdata),
   .rsp_tlast  (rsp_tlast),
   .rsp_tuser  (rsp_tuser)
);

// ===== verif/c_escape_string_decoder_tb.sv =====
// Self-checking testbench for the C string escape decoder.
// Drives string bodies over the request stream and checks every response
// against an in-line decoder model. Depends on cesd_pkg and the block's RTL.
`timescale 1ns / 100ps

module c_escape_string_decoder_tb;

   typedef enum logic [2:0] {
      MODE_NORMAL, MODE_ESC, MODE_OCT, MODE_HEX, MODE_DISCARD
   } decode_mode_type;

   typedef enum int {
      PH_DIRECT, PH_FREE, PH_SEND_IDLE, PH_RECV_STALL, PH_BOTH, PH_PRESSURE
   } phase_type;

   typedef struct {
      logic [7:0] data;
      logic       last;
   } body_byte_type;

   localparam int             LONG_HOLD     = 200;
   localparam int             PHASE_BYTES   = 18;
   localparam logic [15:0]    COUNT_TOP     = 16'hFFFF;
   localparam logic [7:0]     CH_ZERO       = "0";
   localparam logic [7:0]     CH_X          = "x";

   logic        clock = 1'b0;
   logic        reset = 1'b1;
   logic        req_tvalid = 1'b0;
   logic        req_tready;
   logic [7:0]  req_tdata = 8'h00;   // [7:0] in_byte
   logic        req_tlast = 1'b0;    // in_last
   logic        rsp_tvalid;
   logic        rsp_tready = 1'b0;
   logic [23:0] rsp_tdata;           // [7:0] out_byte, [23:8] out_length
   logic        rsp_tlast;           // out_last
   logic        rsp_tuser;           // out_error

   body_byte_type         pending_q[$];
   cesd_pkg::entry_type   decoded_q[$];
   logic [7:0]            text_q[$];

   decode_mode_type dec_mode   = MODE_NORMAL;
   logic [1:0]      digit_cnt  = 2'd0;
   logic [8:0]      esc_acc    = 9'd0;
   logic [15:0]     byte_count = 16'd0;

   phase_type phase          = PH_DIRECT;
   int        send_idle_pct  = 0;
   int        recv_stall_pct = 0;
   logic      hold_rsp       = 1'b0;
   logic      req_taken      = 1'b0;
   int        errors         = 0;

   c_escape_string_decoder i_dut (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .req_tlast  (req_tlast),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata),
      .rsp_tlast  (rsp_tlast),
      .rsp_tuser  (rsp_tuser)
   );

   always begin
      #1 clock = 1'b1;
      #1 clock = 1'b0;
   end

   // ---------------------------------------------------------------- model

   function automatic void clear_string();
      dec_mode   = MODE_NORMAL;
      digit_cnt  = 2'd0;
      esc_acc    = 9'd0;
      byte_count = 16'd0;
   endfunction

   function automatic void count_byte();
      if (byte_count != COUNT_TOP) byte_count++;
   endfunction

   function automatic void expect_result(logic [7:0] b, logic last, logic err);
      cesd_pkg::entry_type e;
      e.data   = b;
      e.last   = last;
      e.error  = err;
      e.length = byte_count;
      decoded_q.push_back(e);
   endfunction

   function automatic void expect_data(logic [7:0] b);
      count_byte();
      expect_result(b, 1'b0, 1'b0);
   endfunction

   function automatic bit is_octal(logic [7:0] b);
      return (b >= "0") && (b <= "7");
   endfunction

   function automatic int hex_value(logic [7:0] b);
      if ((b >= "0") && (b <= "9")) return int'(b - "0");
      if ((b >= "a") && (b <= "f")) return int'(b - "a") + 10;
      if ((b >= "A") && (b <= "F")) return int'(b - "A") + 10;
      return -1;
   endfunction

   // Returns 1 when the byte makes the pending escape malformed.
   function automatic bit absorb_byte(logic [7:0] b);
      int         h;
      logic [7:0] c;
      h = hex_value(b);
      if (dec_mode == MODE_OCT) begin
         if (is_octal(b)) begin
            if (digit_cnt == 2'd3) return 1'b1;
            esc_acc = {esc_acc[5:0], b[2:0]};
            digit_cnt++;
            return 1'b0;
         end
         // The run ends here and this byte is decoded as a fresh one.
         expect_data(esc_acc[7:0]);
         dec_mode = MODE_NORMAL;
      end else if (dec_mode == MODE_HEX) begin
         if (h >= 0) begin
            if (digit_cnt == 2'd2) return 1'b1;
            esc_acc = {esc_acc[4:0], h[3:0]};
            digit_cnt++;
            return 1'b0;
         end
         if (digit_cnt != 2'd2) return 1'b1;
         expect_data(esc_acc[7:0]);
         dec_mode = MODE_NORMAL;
      end else if (dec_mode == MODE_ESC) begin
         if (is_octal(b)) begin
            dec_mode  = MODE_OCT;
            digit_cnt = 2'd1;
            esc_acc   = {6'd0, b[2:0]};
            return 1'b0;
         end
         if (b == CH_X) begin
            dec_mode  = MODE_HEX;
            digit_cnt = 2'd0;
            esc_acc   = 9'd0;
            return 1'b0;
         end
         case (b)
            "n":     c = 8'd10;
            "t":     c = 8'd9;
            "b":     c = 8'd8;
            "v":     c = 8'd11;
            "r":     c = 8'd13;
            "f":     c = 8'd12;
            "\\":    c = b;
            "'":     c = b;
            "\"":    c = b;
            "?":     c = b;
            default: return 1'b1;
         endcase
         expect_data(c);
         dec_mode = MODE_NORMAL;
         return 1'b0;
      end
      if (b == cesd_pkg::CHAR_BACKSLASH) begin
         dec_mode = MODE_ESC;
         return 1'b0;
      end
      expect_data(b);
      dec_mode = MODE_NORMAL;
      return 1'b0;
   endfunction

   function automatic bit flush_pending();
      if (dec_mode == MODE_ESC) return 1'b1;
      if (dec_mode == MODE_OCT) begin
         expect_data(esc_acc[7:0]);
      end else if (dec_mode == MODE_HEX) begin
         if (digit_cnt != 2'd2) return 1'b1;
         expect_data(esc_acc[7:0]);
      end
      return 1'b0;
   endfunction

   function automatic void predict_transfer(logic [7:0] b, logic last);
      bit bad;
      if (dec_mode == MODE_DISCARD) begin
         if (last) clear_string();
         return;
      end
      bad = absorb_byte(b);
      if (!bad && last) bad = flush_pending();
      if (bad) begin
         expect_result(8'd0, 1'b1, 1'b1);
         if (last) clear_string();
         else dec_mode = MODE_DISCARD;
         return;
      end
      if (last) begin
         count_byte();
         expect_result(8'd0, 1'b1, 1'b0);
         clear_string();
      end
   endfunction

   function automatic void check_field(string name, int want, int got);
      if (want != got) begin
         $display("%0t: %s mismatch, expected %0d, got %0d", $time, name, want, got);
         errors++;
      end
   endfunction

   // ---------------------------------------------------------- driver side

   always @(negedge clock) begin
      body_byte_type item;
      if (reset) begin
         req_tvalid <= 1'b0;
      end else if (!req_tvalid || req_taken) begin
         if (pending_q.size() != 0 && $urandom_range(0, 99) >= send_idle_pct) begin
            item = pending_q.pop_front();
            req_tvalid <= 1'b1;
            req_tdata  <= item.data;
            req_tlast  <= item.last;
         end else begin
            req_tvalid <= 1'b0;
         end
      end
   end

   always @(negedge clock) begin
      rsp_tready <= !reset && !hold_rsp && ($urandom_range(0, 99) >= recv_stall_pct);
   end

   // Responses are checked before the current request is predicted, so a
   // response that appears in the same cycle as its request is caught.
   always @(posedge clock) begin
      cesd_pkg::entry_type want;
      if (reset) begin
         req_taken <= 1'b0;
      end else begin
         if (rsp_tvalid && rsp_tready) begin
            if (decoded_q.size() == 0) begin
               $display("%0t: unexpected response, got byte %0d last %0b error %0b length %0d",
                        $time, rsp_tdata[7:0], rsp_tlast, rsp_tuser, rsp_tdata[23:8]);
               errors++;
            end else begin
               want = decoded_q.pop_front();
               check_field("out_byte", want.data, rsp_tdata[7:0]);
               check_field("out_last", want.last, rsp_tlast);
               check_field("out_error", want.error, rsp_tuser);
               check_field("out_length", want.length, rsp_tdata[23:8]);
            end
         end
         if (req_tvalid && req_tready) predict_transfer(req_tdata, req_tlast);
         req_taken <= req_tvalid && req_tready;
      end
   end

   // ------------------------------------------------------------- stimulus

   function automatic void queue_text(string s);
      body_byte_type item;
      for (int i = 0; i < s.len(); i++) begin
         item.data = s[i];
         item.last = (i == s.len() - 1);
         pending_q.push_back(item);
      end
   endfunction

   function automatic void queue_byte(logic [7:0] b, logic last);
      body_byte_type item;
      item.data = b;
      item.last = last;
      pending_q.push_back(item);
   endfunction

   function automatic logic [7:0] pick(string s);
      return s[$urandom_range(0, s.len() - 1)];
   endfunction

   function automatic void add_good_token();
      logic [7:0] b;
      int         k;
      case ($urandom_range(0, 5))
         0, 1, 2: begin
            b = 8'($urandom_range(0, 255));
            if (b == cesd_pkg::CHAR_BACKSLASH) b = "A";
            text_q.push_back(b);
         end
         3: begin
            text_q.push_back(cesd_pkg::CHAR_BACKSLASH);
            text_q.push_back(pick("ntbvrf\\'\"?"));
         end
         4: begin
            text_q.push_back(cesd_pkg::CHAR_BACKSLASH);
            k = $urandom_range(1, 3);
            repeat (k) text_q.push_back(8'(CH_ZERO + $urandom_range(0, 7)));
         end
         default: begin
            text_q.push_back(cesd_pkg::CHAR_BACKSLASH);
            text_q.push_back(CH_X);
            repeat (2) text_q.push_back(pick("0123456789abcdefABCDEF"));
         end
      endcase
   endfunction

   function automatic void add_bad_token(bit at_end);
      string hex = "0123456789abcdefABCDEF";
      text_q.push_back(cesd_pkg::CHAR_BACKSLASH);
      if (at_end && $urandom_range(0, 1)) begin
         // Trailing backslash, or a hex run cut short by the end of the string.
         if ($urandom_range(0, 1)) begin
            text_q.push_back(CH_X);
            if ($urandom_range(0, 1)) text_q.push_back(pick(hex));
         end
         return;
      end
      case ($urandom_range(0, 3))
         0: text_q.push_back(pick("acdeghkz89"));
         1: repeat (4) text_q.push_back(8'(CH_ZERO + $urandom_range(0, 7)));
         2: begin
            text_q.push_back(CH_X);
            if ($urandom_range(0, 1)) text_q.push_back(pick(hex));
            text_q.push_back(pick("gz- +"));
         end
         default: begin
            text_q.push_back(CH_X);
            repeat (3) text_q.push_back(pick(hex));
         end
      endcase
   endfunction

   // Builds one string body; most are well formed, some carry one bad escape,
   // and a few are raw noise rich in backslashes and digits.
   function automatic int queue_random_string();
      int style;
      int n_tok;
      int bad_at;
      int n;
      text_q.delete();
      style = $urandom_range(0, 99);
      n_tok = $urandom_range(1, 8);
      if (style < 15) begin
         repeat (2 * n_tok) begin
            if ($urandom_range(0, 1)) text_q.push_back(pick("\\\\01789xXaFg"));
            else text_q.push_back(8'($urandom_range(0, 255)));
         end
      end else begin
         bad_at = (style < 40) ? $urandom_range(0, n_tok) : -1;
         for (int i = 0; i <= n_tok; i++) begin
            if (i == bad_at) add_bad_token(i == n_tok);
            else if (i < n_tok) add_good_token();
         end
      end
      n = text_q.size();
      for (int i = 0; i < n; i++) queue_byte(text_q[i], i == n - 1);
      return n;
   endfunction

   function automatic void queue_random_phase();
      int n;
      n = 0;
      while (n < PHASE_BYTES) n += queue_random_string();
   endfunction

   task automatic wait_drained();
      while (pending_q.size() != 0 || req_tvalid || decoded_q.size() != 0)
         @(posedge clock);
   endtask

   task automatic run_phase(phase_type p, int send_pct, int recv_pct);
      send_idle_pct  = send_pct;
      recv_stall_pct = recv_pct;
      queue_random_phase();
      phase = p;
      wait_drained();
   endtask

   // The long response hold-off, counted in its own process so that the
   // driver keeps offering requests while the block backs up.
   initial begin
      wait (phase == PH_PRESSURE);
      @(posedge clock);
      hold_rsp = 1'b1;
      repeat (LONG_HOLD) @(posedge clock);
      hold_rsp = 1'b0;
   end

   initial begin
      #2000000;
      $display("Testbench completed WITH ERRORS");
      $finish;
   end

   initial begin
      repeat (5) @(posedge clock);
      @(negedge clock) reset <= 1'b0;

      // Directed strings: byte extremes, octal truncation and flush, an octal
      // run ended by a new escape, hex flush, and every malformed escape kind but an overlong hex run.
      queue_byte(8'h00, 1'b0);
      queue_byte(8'hFF, 1'b1);
      queue_text("\\777\\12\\n\\0");
      queue_text("\\x4a-\\xFf");
      queue_text("\\1234\\");
      queue_text("\\x1g");
      queue_text("\\8");
      queue_text("\\9z");
      queue_text("\\");
      queue_text("\\xF");
      wait_drained();

      run_phase(PH_FREE, 0, 0);
      run_phase(PH_SEND_IDLE, 51, 0);
      run_phase(PH_RECV_STALL, 0, 51);
      run_phase(PH_BOTH, 13, 13);
      run_phase(PH_PRESSURE, 0, 0);
      run_phase(PH_FREE, 0, 0);

      repeat (20) @(posedge clock);
      if (errors == 0) begin
         $display("Testbench completed without errors");
      end else begin
         $display("Testbench completed WITH ERRORS");
      end
      $finish;
   end

endmodule
